// ----- hdl/ackq_pkg.sv -----
package ackq_pkg;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned HANDLE_W = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [ID_W-1:0]     msg_id;
      logic [HANDLE_W-1:0] message_handle;
      logic [HANDLE_W-1:0] session_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] message_out;
      logic [HANDLE_W-1:0] session_out;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] message;
      logic [HANDLE_W-1:0] session;
   } entry_type;

endpackage

// ----- hdl/ackq_store.sv -----
module ackq_store #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  ackq_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output ackq_pkg::entry_type rd_data
);
   import ackq_pkg::*;

   entry_type entry_mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ack_queue_keyed_removal.sv -----
// Ordered acknowledgement queue with removal by message id.
// Request channel: req_data is taken at a rising edge with start high and
// busy low. Ops: insert at tail, remove oldest entry with matching id, pop
// front. Every item gives exactly one result on rsp_data, shown for one
// cycle with rsp_valid high; the receiver cannot hold it off.
// Latency: insert, unused op, or remove/pop on an empty queue answer in
// the next cycle and busy stays low, so such items may follow back to back.
// Remove and pop walk the entry store through one read port and one id
// comparator: the search reads entries from the front until a match or the
// end, the gap is then closed by moving each later entry down one slot, and
// then the result follows. Busy is high throughout the walk and drops as
// the result shows.
// Reset clears the occupancy and the sequencer; stored entries are not
// cleared, as only slots below the occupancy are ever read.
module ack_queue_keyed_removal #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ackq_pkg::req_type req_data,
   output logic              rsp_valid,
   output ackq_pkg::rsp_type rsp_data
);
   import ackq_pkg::*;

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;

   function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
      logic [CW+OCC_W-1:0] ext;
      ext = {{OCC_W{1'b0}}, c};
      return ext[OCC_W-1:0];
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ID_W-1:0]     key_ff, key_in;
   logic [HANDLE_W-1:0] hit_msg_ff, hit_msg_in;
   logic [HANDLE_W-1:0] hit_ses_ff, hit_ses_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   entry_type     rd_data;
   logic          accept;
   logic          hit;
   logic [CW-1:0] scan_prev;

   ackq_store #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rd_en     = (scan_ff < count_ff);
   assign hit       = pend_ff && ((op_ff == OP_POP) || (rd_data.id == key_ff));
   assign scan_prev = scan_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      wr_ptr_in    = wr_ptr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      hit_msg_in   = hit_msg_ff;
      hit_ses_in   = hit_ses_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = wr_ptr_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in              = req_data.op;
               key_in             = req_data.msg_id;
               scan_in            = '0;
               pend_in            = 1'b0;
               rsp_in.message_out = '0;
               rsp_in.session_out = '0;
               rsp_in.status      = STATUS_MISS;
               rsp_in.occupancy   = occ_of(count_ff);
               unique case (req_data.op)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= DEPTH_C) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        wr_addr          = count_ff[AW-1:0];
                        wr_data.id       = req_data.msg_id;
                        wr_data.message  = req_data.message_handle;
                        wr_data.session  = req_data.session_handle;
                        count_in         = count_ff + 1'b1;
                        rsp_in.status    = STATUS_OK;
                        rsp_in.occupancy = occ_of(count_ff + 1'b1);
                     end
                  end
                  OP_REMOVE, OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               hit_msg_in = rd_data.message;
               hit_ses_in = rd_data.session;
               wr_ptr_in  = scan_prev[AW-1:0];
               pend_in    = 1'b0;
               state_in   = S_SHIFT;
            end else if (scan_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en     = 1'b1;
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
            if (scan_ff >= count_ff) begin
               count_in           = count_ff - 1'b1;
               rsp_in.status      = STATUS_OK;
               rsp_in.message_out = hit_msg_ff;
               rsp_in.session_out = hit_ses_ff;
               rsp_in.occupancy   = occ_of(count_ff - 1'b1);
               rsp_valid_in       = 1'b1;
               pend_in            = 1'b0;
               state_in           = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff  <= wr_ptr_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      hit_msg_ff <= hit_msg_in;
      hit_ses_ff <= hit_ses_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE))
      else $error("result strobe while sequencer active");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("occupancy beyond queue depth");

   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == OP_REMOVE || req_data.op == OP_POP)
       && (count_ff != '0)) |=> busy)
      else $error("remove or pop on non-empty queue did not start a walk");

   a_full_only_at_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_FULL)) |-> (count_ff == DEPTH_C))
      else $error("full reported below queue depth");

endmodule
